// ----- rtl/core/first_fit_region_allocator_top_macros.svh -----
// Assertion macros for the region allocator checker.
// Depends on signals named clk and arst_n in the scope of use.
`ifndef FIRST_FIT_REGION_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_REGION_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define FFRA_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("allocator check failed (same cycle)");

// next-cycle implication
`define FFRA_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("allocator check failed (next cycle)");

`endif

// ----- rtl/core/ffra_pkg.sv -----
// Shared types and constants of the first-fit region allocator.
// No dependencies.
package ffra_pkg;

	localparam int MAX_REGIONS_DEF = 64;
	localparam int ADDR_WIDTH_DEF  = 48;
	localparam logic [5:0] MIN_ALIGN_RST = 6'd12;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_ALLOC = 2'd1;
	localparam logic [1:0] OP_FREE  = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOFIT    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_MARK,
		CELL_SPLIT,
		CELL_FREE,
		CELL_FREE_MN,
		CELL_MERGE_PREV
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     sel;
		logic     sel_left;
		logic     sel_right;
		logic     ge;
		logic     tail;
	} cell_ctl_t;

endpackage

// ----- rtl/core/ffra_cell.sv -----
// One table entry of the allocator chain: base, size, used mark.
// Depends on ffra_pkg; trades data with its left and right neighbors.
module ffra_cell #(
	parameter int ADDR_WIDTH = ffra_pkg::ADDR_WIDTH_DEF
) (
	input  logic                  clk,
	input  ffra_pkg::cell_ctl_t   ctl,
	input  logic [ADDR_WIDTH-1:0] ld_base,
	input  logic [ADDR_WIDTH-1:0] ld_size,
	input  logic [ADDR_WIDTH-1:0] key,
	input  logic [ADDR_WIDTH-1:0] left_base,
	input  logic [ADDR_WIDTH-1:0] left_size,
	input  logic                  left_used,
	input  logic [ADDR_WIDTH-1:0] right_base,
	input  logic [ADDR_WIDTH-1:0] right_size,
	input  logic                  right_used,
	output logic [ADDR_WIDTH-1:0] base,
	output logic [ADDR_WIDTH-1:0] size,
	output logic                  used
);

	logic [ADDR_WIDTH-1:0] base_q, size_q;
	logic                  used_q;

	assign base = base_q;
	assign size = size_q;
	assign used = used_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			ffra_pkg::CELL_LOAD: begin
				if (ctl.tail) begin
					base_q <= ld_base;
					size_q <= ld_size;
					used_q <= 1'b0;
				end
			end
			ffra_pkg::CELL_MARK: begin
				if (ctl.sel) used_q <= 1'b1;
			end
			ffra_pkg::CELL_SPLIT: begin
				if (ctl.sel) begin
					size_q <= key;
					used_q <= 1'b1;
				end else if (ctl.sel_left) begin
					// remainder of the split region
					base_q <= left_base + key;
					size_q <= left_size - key;
					used_q <= 1'b0;
				end else if (ctl.ge) begin
					base_q <= left_base;
					size_q <= left_size;
					used_q <= left_used;
				end
			end
			ffra_pkg::CELL_FREE: begin
				if (ctl.sel) used_q <= 1'b0;
			end
			ffra_pkg::CELL_FREE_MN: begin
				if (ctl.sel) begin
					used_q <= 1'b0;
					size_q <= size_q + right_size;
				end else if (ctl.ge) begin
					base_q <= right_base;
					size_q <= right_size;
					used_q <= right_used;
				end
			end
			ffra_pkg::CELL_MERGE_PREV: begin
				if (ctl.sel_right) begin
					size_q <= size_q + right_size;
				end else if (ctl.ge) begin
					base_q <= right_base;
					size_q <= right_size;
					used_q <= right_used;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/core/first_fit_region_allocator_top.sv -----
// An operation steps through the calc, select, apply, merge and out states before its result
// is registered at the output; out waits while an earlier result is still held unaccepted.
// A new operation is taken only in idle, after the last one has left out, as the sequencer steps
// the shared cell row through rounding, first-fit select, update and the previous-region merge.
// Reset (arst_n low): entry count cleared, min alignment back to 2^12, no result pending.
// Cell contents are not cleared; only entries below the count are ever looked at.
module first_fit_region_allocator_top #(
	parameter int MAX_REGIONS = ffra_pkg::MAX_REGIONS_DEF,
	parameter int ADDR_WIDTH  = ffra_pkg::ADDR_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [5:0]            cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            opcode,
	input  logic [ADDR_WIDTH-1:0] region_addr,
	input  logic [ADDR_WIDTH-1:0] length,
	input  logic [5:0]            align_log2,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic [ADDR_WIDTH-1:0] granted_base,
	output logic [ADDR_WIDTH-1:0] granted_size
);

	localparam int CW = $clog2(MAX_REGIONS + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_REGIONS);
	localparam logic [MAX_REGIONS-1:0] ONE_V = MAX_REGIONS'(1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CALC  = 6'b000010,
		S_SEL   = 6'b000100,
		S_APPLY = 6'b001000,
		S_MERGE = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	logic [5:0]    minal_q;
	logic [CW-1:0] count_q;

	// latched request
	logic [1:0]            op_q;
	logic [ADDR_WIDTH-1:0] addr_q, len_q, key_q;
	logic [5:0]            alog_q;
	logic                  nofit_q;

	// selection results
	logic [MAX_REGIONS-1:0] sel_q, ge_q;
	logic                   any_q, exact_q, mp_q;

	// pending result and output register
	logic [1:0]            res_status_q, status_q;
	logic [ADDR_WIDTH-1:0] res_base_q, res_size_q, gbase_q, gsize_q;
	logic                  out_valid_q;

	// cell row signals
	logic [ADDR_WIDTH-1:0]  base_w [MAX_REGIONS];
	logic [ADDR_WIDTH-1:0]  size_w [MAX_REGIONS];
	logic [MAX_REGIONS-1:0] used_w, vld, hits, eqv, nf, pf;
	ffra_pkg::cell_ctl_t    ctl_w [MAX_REGIONS];

	logic in_xfer;
	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign granted_base = gbase_q;
	assign granted_size = gsize_q;

	// size rounding: round up to 2^max(align, min), reject overflow and zero length
	logic [5:0]            sh;
	logic                  big;
	logic [ADDR_WIDTH-1:0] m1, rnd;
	logic [ADDR_WIDTH:0]   sum;
	logic                  calc_nofit;

	always_comb begin
		sh  = (alog_q < minal_q) ? minal_q : alog_q;
		big = ({1'b0, sh} >= 7'(ADDR_WIDTH));
		m1  = ~({ADDR_WIDTH{1'b1}} << sh);
		sum = {1'b0, len_q} + {1'b0, m1};
		rnd = sum[ADDR_WIDTH-1:0] & ~m1;
		calc_nofit = (len_q == '0) || big || sum[ADDR_WIDTH];
	end

	// first hit in address order: lowest set bit, plus mask of it and all above
	logic [MAX_REGIONS-1:0] ff, ge_n;
	assign ff   = hits & (~hits + ONE_V);
	assign ge_n = ~(ff - ONE_V);

	// neighbor tests on the selected entry and the granted base
	logic                  mn, mp;
	logic [ADDR_WIDTH-1:0] gb;
	always_comb begin
		mn = |(sel_q & nf);
		mp = |(sel_q & pf);
		gb = '0;
		for (int k = 0; k < MAX_REGIONS; k++)
			gb = gb | ({ADDR_WIDTH{sel_q[k]}} & base_w[k]);
	end

	// sequencer decisions
	ffra_pkg::cell_op_t    cmd_op;
	logic [1:0]            ap_status;
	logic                  ap_grant, cnt_inc, cnt_dec, ap_mp;

	always_comb begin
		cmd_op    = ffra_pkg::CELL_HOLD;
		ap_status = ffra_pkg::ST_OK;
		ap_grant  = 1'b0;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		ap_mp     = 1'b0;
		if (state_q == S_APPLY) begin
			case (op_q)
				ffra_pkg::OP_ADD: begin
					if (count_q == CNT_MAX) begin
						ap_status = ffra_pkg::ST_FULL;
					end else begin
						cmd_op  = ffra_pkg::CELL_LOAD;
						cnt_inc = 1'b1;
					end
				end
				ffra_pkg::OP_ALLOC: begin
					if (nofit_q || !any_q) begin
						ap_status = ffra_pkg::ST_NOFIT;
					end else if (exact_q) begin
						cmd_op   = ffra_pkg::CELL_MARK;
						ap_grant = 1'b1;
					end else if (count_q == CNT_MAX) begin
						// split needs a free slot; no other region is tried
						ap_status = ffra_pkg::ST_FULL;
					end else begin
						cmd_op   = ffra_pkg::CELL_SPLIT;
						cnt_inc  = 1'b1;
						ap_grant = 1'b1;
					end
				end
				ffra_pkg::OP_FREE: begin
					if (!any_q) begin
						ap_status = ffra_pkg::ST_NOTFOUND;
					end else begin
						cmd_op  = mn ? ffra_pkg::CELL_FREE_MN : ffra_pkg::CELL_FREE;
						cnt_dec = mn;
						ap_mp   = mp;
					end
				end
				default: ;
			endcase
		end else if (state_q == S_MERGE && mp_q) begin
			cmd_op  = ffra_pkg::CELL_MERGE_PREV;
			cnt_dec = 1'b1;
		end
	end

	// cell row
	for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
		localparam logic [CW-1:0] KIDX = CW'(g);
		logic [ADDR_WIDTH-1:0] lb, ls, rb, rs;
		logic                  lu, ru, sl, sr;

		if (g > 0) begin : g_l
			assign lb = base_w[g-1];
			assign ls = size_w[g-1];
			assign lu = used_w[g-1];
			assign sl = sel_q[g-1];
			assign pf[g] = !used_w[g-1];
		end else begin : g_l0
			assign lb = '0;
			assign ls = '0;
			assign lu = 1'b0;
			assign sl = 1'b0;
			assign pf[g] = 1'b0;
		end

		if (g < MAX_REGIONS - 1) begin : g_r
			assign rb = base_w[g+1];
			assign rs = size_w[g+1];
			assign ru = used_w[g+1];
			assign sr = sel_q[g+1];
			assign nf[g] = vld[g+1] && !used_w[g+1];
		end else begin : g_r0
			assign rb = '0;
			assign rs = '0;
			assign ru = 1'b0;
			assign sr = 1'b0;
			assign nf[g] = 1'b0;
		end

		assign vld[g] = (KIDX < count_q);
		assign eqv[g] = (size_w[g] == key_q);
		assign hits[g] = (op_q == ffra_pkg::OP_ALLOC)
			? (vld[g] && !used_w[g] && size_w[g] >= key_q)
			: (vld[g] && base_w[g] == addr_q && eqv[g]);

		assign ctl_w[g] = '{op: cmd_op, sel: sel_q[g], sel_left: sl, sel_right: sr,
			ge: ge_q[g], tail: (KIDX == count_q)};

		ffra_cell #(.ADDR_WIDTH(ADDR_WIDTH)) u_cell (
			.clk        (clk),
			.ctl        (ctl_w[g]),
			.ld_base    (addr_q),
			.ld_size    (len_q),
			.key        (key_q),
			.left_base  (lb),
			.left_size  (ls),
			.left_used  (lu),
			.right_base (rb),
			.right_size (rs),
			.right_used (ru),
			.base       (base_w[g]),
			.size       (size_w[g]),
			.used       (used_w[g])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			minal_q     <= ffra_pkg::MIN_ALIGN_RST;
			count_q     <= '0;
			mp_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) minal_q <= cfg_wdata;
			if (cnt_inc) count_q <= count_q + CW'(1);
			else if (cnt_dec) count_q <= count_q - CW'(1);
			case (state_q)
				S_IDLE:  if (in_xfer) state_q <= S_CALC;
				S_CALC:  state_q <= S_SEL;
				S_SEL:   state_q <= S_APPLY;
				S_APPLY: begin
					mp_q    <= ap_mp;
					state_q <= S_MERGE;
				end
				S_MERGE: state_q <= S_DONE;
				S_DONE:  if (!out_valid_q || out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_DONE && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q   <= opcode;
			addr_q <= region_addr;
			len_q  <= length;
			alog_q <= align_log2;
		end
		if (state_q == S_CALC) begin
			key_q   <= (op_q == ffra_pkg::OP_ALLOC) ? rnd : len_q;
			nofit_q <= calc_nofit;
		end
		if (state_q == S_SEL) begin
			sel_q   <= ff;
			ge_q    <= ge_n;
			any_q   <= |hits;
			exact_q <= |(ff & eqv);
		end
		if (state_q == S_APPLY) begin
			res_status_q <= ap_status;
			res_base_q   <= ap_grant ? gb : '0;
			res_size_q   <= ap_grant ? key_q : '0;
		end
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			status_q <= res_status_q;
			gbase_q  <= res_base_q;
			gsize_q  <= res_size_q;
		end
	end

endmodule

// ----- rtl/core/ffra_checker.sv -----
// Port-level checks of the region allocator, bound to the top level.
// Depends on ffra_pkg and first_fit_region_allocator_top_macros.svh.
`include "first_fit_region_allocator_top_macros.svh"

module ffra_checker #(
	parameter int ADDR_WIDTH = ffra_pkg::ADDR_WIDTH_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [1:0]            status,
	input logic [ADDR_WIDTH-1:0] granted_base,
	input logic [ADDR_WIDTH-1:0] granted_size
);

	`FFRA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(granted_base) && $stable(granted_size))
	`FFRA_ASSERT_NXT(a_busy_after_xfer, in_valid && in_ready, !in_ready && !$rose(out_valid))
	`FFRA_ASSERT_IMP(a_fail_no_grant, out_valid && status != ffra_pkg::ST_OK, granted_base == '0 && granted_size == '0)
	`FFRA_ASSERT_IMP(a_zero_size_no_base, out_valid && granted_size == '0, granted_base == '0)

endmodule

bind first_fit_region_allocator_top ffra_checker #(.ADDR_WIDTH(ADDR_WIDTH)) u_ffra_checker (.*);
